// ----- rtl/htd_pkg.sv -----
package htd_pkg;

    // Node store geometry.
    localparam int NODE_COUNT   = 512;
    localparam int SYMBOL_COUNT = 256;
    localparam int NODE_W       = $clog2(NODE_COUNT);
    localparam int USED_W       = NODE_W + 1;

    localparam logic [USED_W-1:0] USED_FULL  = USED_W'(NODE_COUNT);
    localparam logic [USED_W-1:0] USED_RESET = USED_W'(1);
    localparam logic [8:0]        SYM_LIMIT  = 9'(SYMBOL_COUNT);
    localparam logic [3:0]        BYTE_BITS  = 4'd8;

    // Request opcodes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_SYMBOL  = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
        logic       code_bit;
        logic       code_end;
        logic [7:0] payload;
        logic [3:0] valid_bits;
    } in_t;

    typedef struct packed {
        logic [7:0] decoded_symbol;
        logic [1:0] status;
        logic       last;
    } out_t;

    // Child pointers of one node; zero means no child, as the root is never a child.
    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } kids_t;

endpackage

// ----- rtl/huffman_tree_decoder_unit.sv -----
// Huffman code tree decoder.
//
// Requests arrive on the s_ channel (s_valid, s_ready, s_data) and results
// leave on the m_ channel (m_valid, m_ready, m_data); both use a valid/ready
// handshake. A clear request resets the tree and gives no result. A load
// request adds one code bit to the tree; it gives a result only when the node
// store is full. A decode request walks the payload byte most significant bit
// first and gives one result per completed symbol, and a single error result
// on a missing branch or while the failure flag is set. The final result of
// each request carries last.
// A load reads its node, checks the branch and, when it is new, links a fresh node.
// Every decode bit needs one dependent read of the node store, one per cycle while
// the walk is not paused, through its single registered read port. The payload
// byte is consumed from a shift register one bit per cycle while the walk is not paused.
// Results pass through a one-entry pending stage and then the output register.
// The newest result of a decode stays pending until the walk shows whether another
// follows, so that last can be set on it. When the receiver stalls and both are
// occupied, the walk pauses until m_ready. Reset (aresetn, synchronous, active low)
// empties the tree to a childless root and clears the failure flag at once, with
// no sweep.
module huffman_tree_decoder_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  htd_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output htd_pkg::out_t   m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_CHK,
        ST_LD_LINK,
        ST_DC_CUR,
        ST_DC_RUN,
        ST_ERR
    } state_t;

    state_t                         state_reg, state_next;
    htd_pkg::kids_t                 root_reg, root_next;
    logic [htd_pkg::USED_W-1:0]     nodes_used_reg, nodes_used_next;
    logic [htd_pkg::NODE_W-1:0]     load_cur_reg, load_cur_next;
    logic [htd_pkg::NODE_W-1:0]     dec_cur_reg, dec_cur_next;
    logic                           failed_reg, failed_next;
    logic [7:0]                     sym_reg, sym_next;
    logic                           bit_reg, bit_next;
    logic                           end_reg, end_next;
    logic [7:0]                     shift_reg, shift_next;
    logic [3:0]                     cnt_reg, cnt_next;
    logic [1:0]                     err_st_reg, err_st_next;
    htd_pkg::kids_t                 link_reg, link_next;
    logic                           pend_valid_reg, pend_valid_next;
    htd_pkg::out_t                  pend_reg, pend_next;
    logic                           m_valid_reg, m_valid_next;
    htd_pkg::out_t                  m_data_reg, m_data_next;

    // Node store: child pointers and symbols in two memories, the root in flops.
    htd_pkg::kids_t                 child_mem [htd_pkg::NODE_COUNT];
    logic [7:0]                     sym_mem [htd_pkg::NODE_COUNT];
    htd_pkg::kids_t                 rd_kids_reg;
    logic [7:0]                     rd_sym_reg;
    logic [htd_pkg::NODE_W-1:0]     addr_q_reg;

    logic                           rd_en;
    logic [htd_pkg::NODE_W-1:0]     rd_addr;
    logic                           child_we;
    logic [htd_pkg::NODE_W-1:0]     child_waddr;
    htd_pkg::kids_t                 child_wdata;
    logic                           sym_we;
    logic [htd_pkg::NODE_W-1:0]     sym_waddr;
    logic [7:0]                     sym_wdata;

    htd_pkg::kids_t                 view_kids;
    htd_pkg::kids_t                 step_src;
    logic [htd_pkg::NODE_W-1:0]     step_child;
    logic [htd_pkg::NODE_W-1:0]     ld_child;
    logic [htd_pkg::NODE_W-1:0]     new_idx;
    logic                           leaf;
    logic                           sym_ok;
    logic                           out_free;
    logic                           push;
    logic                           go;
    logic                           new_res;
    htd_pkg::out_t                  new_data;
    logic                           fin_mark;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The node just read; address zero is the root, which lives in flops.
    assign view_kids = (addr_q_reg == '0) ? root_reg : rd_kids_reg;

    // In the walk, the node just reached is a leaf when it has no children.
    assign leaf = (rd_kids_reg.left == '0) && (rd_kids_reg.right == '0);

    // The node from which the next payload bit steps.
    assign step_src   = (state_reg == ST_DC_RUN) ? (leaf ? root_reg : rd_kids_reg) : view_kids;
    assign step_child = shift_reg[7] ? step_src.right : step_src.left;

    assign ld_child = bit_reg ? view_kids.right : view_kids.left;
    assign new_idx  = nodes_used_reg[htd_pkg::NODE_W-1:0];
    assign sym_ok   = ({1'b0, sym_reg} < htd_pkg::SYM_LIMIT);

    // A result may be produced only when the pending stage is free or drains now.
    // A pending result that may still turn out to be the final one of its walk is
    // held until a newer result replaces it or the walk ends.
    assign out_free = !m_valid_reg || m_ready;
    assign push     = pend_valid_reg && out_free && (pend_reg.last || fin_mark || new_res);
    assign go       = !pend_valid_reg || out_free;

    always_comb begin
        state_next      = state_reg;
        root_next       = root_reg;
        nodes_used_next = nodes_used_reg;
        load_cur_next   = load_cur_reg;
        dec_cur_next    = dec_cur_reg;
        failed_next     = failed_reg;
        sym_next        = sym_reg;
        bit_next        = bit_reg;
        end_next        = end_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        err_st_next     = err_st_reg;
        link_next       = link_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        child_we        = 1'b0;
        child_waddr     = '0;
        child_wdata     = '0;
        sym_we          = 1'b0;
        sym_waddr       = '0;
        sym_wdata       = '0;
        new_res         = 1'b0;
        new_data        = '0;
        fin_mark        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.opcode)
                        htd_pkg::OP_CLEAR: begin
                            root_next       = '0;
                            nodes_used_next = htd_pkg::USED_RESET;
                            load_cur_next   = '0;
                            dec_cur_next    = '0;
                            failed_next     = 1'b0;
                        end
                        htd_pkg::OP_LOAD: begin
                            sym_next   = s_data.symbol;
                            bit_next   = s_data.code_bit;
                            end_next   = s_data.code_end;
                            rd_en      = 1'b1;
                            rd_addr    = load_cur_reg;
                            state_next = ST_LD_CHK;
                        end
                        htd_pkg::OP_DECODE: begin
                            if (failed_reg) begin
                                err_st_next = htd_pkg::ST_MISSING;
                                state_next  = ST_ERR;
                            end else begin
                                shift_next = s_data.payload;
                                cnt_next   = (s_data.valid_bits > htd_pkg::BYTE_BITS) ?
                                             htd_pkg::BYTE_BITS : s_data.valid_bits;
                                if (s_data.valid_bits != '0) begin
                                    rd_en      = 1'b1;
                                    rd_addr    = dec_cur_reg;
                                    state_next = ST_DC_CUR;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_LD_CHK: begin
                if (ld_child != '0) begin
                    if (end_reg) begin
                        sym_we        = sym_ok;
                        sym_waddr     = ld_child;
                        sym_wdata     = sym_reg;
                        load_cur_next = '0;
                    end else begin
                        load_cur_next = ld_child;
                    end
                    state_next = ST_IDLE;
                end else if (nodes_used_reg == htd_pkg::USED_FULL) begin
                    load_cur_next = '0;
                    err_st_next   = htd_pkg::ST_FULL;
                    state_next    = ST_ERR;
                end else begin
                    // Allocate a fresh childless node, then link it to its parent.
                    child_we        = 1'b1;
                    child_waddr     = new_idx;
                    child_wdata     = '0;
                    sym_we          = 1'b1;
                    sym_waddr       = new_idx;
                    sym_wdata       = (end_reg && sym_ok) ? sym_reg : 8'd0;
                    nodes_used_next = nodes_used_reg + htd_pkg::USED_W'(1);
                    link_next       = view_kids;
                    if (bit_reg) begin
                        link_next.right = new_idx;
                    end else begin
                        link_next.left = new_idx;
                    end
                    load_cur_next = end_reg ? '0 : new_idx;
                    state_next    = ST_LD_LINK;
                end
            end

            ST_LD_LINK: begin
                if (addr_q_reg == '0) begin
                    root_next = link_reg;
                end else begin
                    child_we    = 1'b1;
                    child_waddr = addr_q_reg;
                    child_wdata = link_reg;
                end
                state_next = ST_IDLE;
            end

            ST_DC_CUR: begin
                if (step_child == '0) begin
                    failed_next  = 1'b1;
                    dec_cur_next = '0;
                    err_st_next  = htd_pkg::ST_MISSING;
                    state_next   = ST_ERR;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = step_child;
                    shift_next = {shift_reg[6:0], 1'b0};
                    cnt_next   = cnt_reg - 4'd1;
                    state_next = ST_DC_RUN;
                end
            end

            ST_DC_RUN: begin
                if (go) begin
                    if (leaf) begin
                        new_res                 = 1'b1;
                        new_data.decoded_symbol = rd_sym_reg;
                        new_data.status         = htd_pkg::ST_SYMBOL;
                        new_data.last           = (cnt_reg == '0);
                        dec_cur_next            = '0;
                    end else begin
                        dec_cur_next = addr_q_reg;
                    end
                    if (cnt_reg == '0) begin
                        fin_mark   = !leaf;
                        state_next = ST_IDLE;
                    end else if (step_child == '0) begin
                        failed_next  = 1'b1;
                        dec_cur_next = '0;
                        err_st_next  = htd_pkg::ST_MISSING;
                        state_next   = ST_ERR;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = step_child;
                        shift_next = {shift_reg[6:0], 1'b0};
                        cnt_next   = cnt_reg - 4'd1;
                    end
                end
            end

            ST_ERR: begin
                if (go) begin
                    new_res         = 1'b1;
                    new_data.status = err_st_reg;
                    new_data.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pending stage and output register. The last flag of a walk that ends
    // without a new result lands on the newest result still held.
    always_comb begin
        pend_valid_next = new_res || (pend_valid_reg && !push);
        if (new_res) begin
            pend_next = new_data;
        end else begin
            pend_next      = pend_reg;
            pend_next.last = pend_reg.last || fin_mark;
        end
        if (push) begin
            m_valid_next     = 1'b1;
            m_data_next      = pend_reg;
            m_data_next.last = pend_reg.last || fin_mark;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            nodes_used_reg <= htd_pkg::USED_RESET;
            load_cur_reg   <= '0;
            dec_cur_reg    <= '0;
            failed_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            nodes_used_reg <= nodes_used_next;
            load_cur_reg   <= load_cur_next;
            dec_cur_reg    <= dec_cur_next;
            failed_reg     <= failed_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        sym_reg    <= sym_next;
        bit_reg    <= bit_next;
        end_reg    <= end_next;
        shift_reg  <= shift_next;
        cnt_reg    <= cnt_next;
        err_st_reg <= err_st_next;
        link_reg   <= link_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (sym_we) begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        if (rd_en) begin
            rd_kids_reg <= child_mem[rd_addr];
            rd_sym_reg  <= sym_mem[rd_addr];
            addr_q_reg  <= rd_addr;
        end
    end

`ifndef SYNTHESIS
    // The allocation count never leaves its range.
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (nodes_used_reg >= htd_pkg::USED_RESET) && (nodes_used_reg <= htd_pkg::USED_FULL))
        else $error("node allocation count out of range");

    // The walk only ever reaches a child, never the root.
    a_walk_child: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DC_RUN) |-> (addr_q_reg != '0))
        else $error("decode walk reached the root as a child");

    // An error result always closes its request and carries no symbol.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status != htd_pkg::ST_SYMBOL)) |->
        (m_data_reg.last && (m_data_reg.decoded_symbol == 8'd0)))
        else $error("error result not final or carries a symbol");

    // Once set, the failure flag drops only through a clear request.
    a_failed_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(failed_reg) |-> $past(s_valid && s_ready && (s_data.opcode == htd_pkg::OP_CLEAR)))
        else $error("failure flag dropped without a clear");
`endif

endmodule
